@@ design/bb3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, sizes and helpers for the 3x3 RGBA box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // line store geometry
    localparam int LINE_PIXELS = 2048;
    localparam int LINE_IDX_W  = $clog2(LINE_PIXELS);
    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int MAX_LINES   = 4096;
    localparam int ROW_W       = $clog2(MAX_LINES);
    localparam int PIX_W       = 32;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // reset frame size
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(512);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(512);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // reciprocal of nine, exact floor for sums up to 9*255
    localparam int          DIV9_SHIFT = 15;
    localparam logic [11:0] DIV9_MUL   = 12'd3641;

    // position of the pixel being accepted
    typedef struct packed {
        logic                  produce;
        logic                  frame_end;
        logic [LINE_IDX_W-1:0] idx;
    } pos_t;

    // floor(sum / 9) by reciprocal multiply
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+12-1:0] prod;
        prod = {12'd0, s} * {{SUM_W{1'b0}}, DIV9_MUL};
        return prod[DIV9_SHIFT +: CHAN_W];
    endfunction

    // one channel of a packed pixel, widened to the sum width
    function automatic logic [SUM_W-1:0] chan(input logic [PIX_W-1:0] px,
                                              input int k);
        return {{(SUM_W-CHAN_W){1'b0}}, px[k*CHAN_W +: CHAN_W]};
    endfunction

endpackage

@@ design/bb3_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read, held when not enabled
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bb3_frame_ctr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_frame_ctr
// Frame size registers, size clamping and column / row position counters.
// ----------------------------------------------------------------------------
module bb3_frame_ctr (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            step,
    output bb3_pkg::pos_t                   pos
);

    localparam int IW = bb3_pkg::LINE_IDX_W;
    localparam int RW = bb3_pkg::ROW_W;
    localparam int WW = bb3_pkg::WIDTH_REG_W;
    localparam int HW = bb3_pkg::HEIGHT_REG_W;

    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [IW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] eff_width;
    logic [HW-1:0] eff_height;
    logic [IW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic          size_wr;

    // clamp the size registers to the supported range
    always_comb begin
        if (width_reg < WW'(3)) begin
            eff_width = WW'(3);
        end else if (width_reg > WW'(bb3_pkg::LINE_PIXELS)) begin
            eff_width = WW'(bb3_pkg::LINE_PIXELS);
        end else begin
            eff_width = width_reg;
        end
        if (height_reg < HW'(3)) begin
            eff_height = HW'(3);
        end else if (height_reg > HW'(bb3_pkg::MAX_LINES)) begin
            eff_height = HW'(bb3_pkg::MAX_LINES);
        end else begin
            eff_height = height_reg;
        end
    end

    assign col_last = IW'(eff_width - WW'(1));
    assign row_last = RW'(eff_height - HW'(1));

    // register writes
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        size_wr     = 1'b0;
        if (cfg_valid) begin
            if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
                width_next = cfg_data[WW-1:0];
                size_wr    = 1'b1;
            end else if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) begin
                height_next = cfg_data[HW-1:0];
                size_wr     = 1'b1;
            end
        end
    end

    // position counters, restarted by any size write
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (step) begin
            if (col_reg == col_last) begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bb3_pkg::WIDTH_RESET;
            height_reg <= bb3_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // interior pixels produce a result
    assign pos.produce   = (row_reg >= RW'(2)) && (col_reg >= IW'(2));
    assign pos.frame_end = (row_reg == row_last) && (col_reg == col_last);
    assign pos.idx       = col_reg;

endmodule

@@ design/bb3_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window
// Two-column window registers and the per-channel mean of nine.
// ----------------------------------------------------------------------------
module bb3_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        shift,
    input  logic [bb3_pkg::PIX_W-1:0]   top,
    input  logic [bb3_pkg::PIX_W-1:0]   mid,
    input  logic [bb3_pkg::PIX_W-1:0]   pix,
    output logic [bb3_pkg::PIX_W-1:0]   result
);

    localparam int SW = bb3_pkg::SUM_W;
    localparam int CW = bb3_pkg::CHAN_W;

    logic [bb3_pkg::PIX_W-1:0] win_reg [6];
    logic [SW-1:0]             sum [3];

    // window shift, one column per advanced beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= pix;
        end
    end

    // nine-term sums and divide by nine per colour channel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = bb3_pkg::chan(win_reg[0], k) + bb3_pkg::chan(win_reg[1], k)
                   + bb3_pkg::chan(win_reg[2], k) + bb3_pkg::chan(win_reg[3], k)
                   + bb3_pkg::chan(win_reg[4], k) + bb3_pkg::chan(win_reg[5], k)
                   + bb3_pkg::chan(top, k) + bb3_pkg::chan(mid, k)
                   + bb3_pkg::chan(pix, k);
            result[k*CW +: CW] = bb3_pkg::div9(sum[k]);
        end
        // centre alpha passes through
        result[3*CW +: CW] = win_reg[4][3*CW +: CW];
    end

endmodule

@@ design/box_blur_3x3_rgba.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba
// Streaming 3x3 mean blur of an RGBA raster with two line stores.
// ----------------------------------------------------------------------------
// Usage:
//  s_ carries input pixels in raster order, one beat per pixel. m_ carries
//  the blurred interior pixels, (height-2) x (width-2) beats per frame,
//  with tlast on the final beat of each output frame. Border pixels give
//  no output beat.
//  The cfg channel writes frame_width (index 0) and frame_height (index 1);
//  either write restarts the position counters so the next pixel begins a
//  new frame. cfg_ready is always high; write only while the block is idle.
//  A pixel accepted on s_ is held in the input stage register, then its
//  result is captured in the output register and appears on m_.
//  Throughput: one pixel per cycle unless m_ stalls, set by the single read
//  and single write port of each line store, used once per pixel.
//  Reset (aresetn low, synchronous) sets the size to 512 x 512, clears the
//  counters, the window and all valid flags. Line store contents are kept.
//  When m_tready is low the output register and the pipeline stage fill,
//  then s_tready drops until the output beat is taken.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgba (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input pixels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // pix_red, pix_green, pix_blue, pix_alpha
    // blurred pixels
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                            m_tlast,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW = bb3_pkg::PIX_W;

    bb3_pkg::pos_t   pos;
    bb3_pkg::pos_t   pos1_reg;
    logic [PW-1:0]   pix1_reg;
    logic            v1_reg, v1_next;
    logic [PW-1:0]   top_rd, mid_rd;
    logic [PW-1:0]   result;
    logic [PW-1:0]   m_tdata_reg;
    logic            m_tlast_reg;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            accept;
    logic            adv;

    // handshake
    assign adv       = v1_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !v1_reg || adv;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bb3_frame_ctr u_ctr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .pos       (pos)
    );

    // line stores, read on accept, written back as the beat advances
    bb3_ram #(.WIDTH(PW), .DEPTH(bb3_pkg::LINE_PIXELS)) u_older (
        .aclk    (aclk),
        .wr_en   (adv),
        .wr_addr (pos1_reg.idx),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (pos.idx),
        .rd_data (top_rd)
    );

    bb3_ram #(.WIDTH(PW), .DEPTH(bb3_pkg::LINE_PIXELS)) u_recent (
        .aclk    (aclk),
        .wr_en   (adv),
        .wr_addr (pos1_reg.idx),
        .wr_data (pix1_reg),
        .rd_en   (accept),
        .rd_addr (pos.idx),
        .rd_data (mid_rd)
    );

    bb3_window u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (adv),
        .top     (top_rd),
        .mid     (mid_rd),
        .pix     (pix1_reg),
        .result  (result)
    );

    // input stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg <= s_tdata;
            pos1_reg <= pos;
        end
    end

    // stage and output valid
    always_comb begin
        v1_next = accept ? 1'b1 : (adv ? 1'b0 : v1_reg);
        if (adv && pos1_reg.produce) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v1_reg       <= v1_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv && pos1_reg.produce) begin
            m_tdata_reg <= result;
            m_tlast_reg <= pos1_reg.frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // a stalled stage keeps its pixel
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !adv |=> v1_reg && $stable(pix1_reg) && $stable(pos1_reg))
        else $error("input stage changed while stalled");

    // line store read and write never meet at one address
    a_ram_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && adv |-> pos.idx != pos1_reg.idx)
        else $error("line store read and write collide");

    // an output beat only appears from an advancing stage
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(adv) && $past(pos1_reg.produce))
        else $error("output beat without a source");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 RGBA box blur. Pixel frames of
// many sizes go in with random gaps and output back-pressure. A behavioural
// copy of the line stores, window and raster counters predicts every output
// beat, and each beat is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CHAN_W       = bb3_pkg::CHAN_W;
    localparam int PIX_W        = bb3_pkg::PIX_W;
    localparam int CFG_IDX_W    = bb3_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = bb3_pkg::CFG_DATA_W;
    localparam int LINE_PIXELS  = bb3_pkg::LINE_PIXELS;
    localparam int WIDTH_REG_W  = bb3_pkg::WIDTH_REG_W;
    localparam int HEIGHT_REG_W = bb3_pkg::HEIGHT_REG_W;
    localparam int MAX_LINES    = bb3_pkg::MAX_LINES;

    localparam logic [CFG_IDX_W-1:0]    REG_FRAME_WIDTH  = bb3_pkg::REG_FRAME_WIDTH;
    localparam logic [CFG_IDX_W-1:0]    REG_FRAME_HEIGHT = bb3_pkg::REG_FRAME_HEIGHT;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET      = bb3_pkg::WIDTH_RESET;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET     = bb3_pkg::HEIGHT_RESET;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int START_ITEMS   = 40;
    localparam int RANDOM_ITEMS  = 540;
    localparam int WIDE_ITEMS    = 48;
    localparam int TALL_ROWS     = 60;
    localparam int HOLD_AFTER    = 30;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 60000;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_FRAME_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              frame_end;
    } blur_px_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // behavioural copy of the blur state
    logic [PIX_W-1:0]        line_recent [LINE_PIXELS];
    logic [PIX_W-1:0]        line_older  [LINE_PIXELS];
    logic [PIX_W-1:0]        win_cols    [6];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    blur_px_t         blur_expect [$];
    logic [PIX_W-1:0] pixel_queue [$];
    int unsigned      pushed_count   = 0;
    int unsigned      accepted_count = 0;
    int unsigned      fail_count     = 0;
    int unsigned      cycle_count    = 0;
    int               stall_req      = 0;
    int               stall_seen     = 0;
    int               src_gap        = 0;
    int               sink_gap       = 0;
    bit               calm           = 1'b0;

    box_blur_3x3_rgba u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int unsigned eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > LINE_PIXELS) return LINE_PIXELS;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 3) return 3;
        if (height_reg > MAX_LINES) return MAX_LINES;
        return height_reg;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] got,
                               input logic [CHAN_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // size write restarts the raster, other indexes are ignored
    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = val[WIDTH_REG_W-1:0];
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = val[HEIGHT_REG_W-1:0];
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    // one input pixel: window mean for interior positions, then shift state
    task automatic advance_raster(input logic [PIX_W-1:0] pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       idx;
        int unsigned       total;
        logic [PIX_W-1:0]  up2;
        logic [PIX_W-1:0]  up1;
        logic [CHAN_W-1:0] mean [3];
        blur_px_t          want;
        w   = eff_width();
        h   = eff_height();
        idx = col_pos % LINE_PIXELS;
        up2 = line_older[idx];
        up1 = line_recent[idx];
        if (row_pos >= 2 && col_pos >= 2) begin
            for (int k = 0; k < 3; k++) begin
                total = up2[k*CHAN_W +: CHAN_W] + up1[k*CHAN_W +: CHAN_W]
                      + pix[k*CHAN_W +: CHAN_W];
                for (int m = 0; m < 6; m++) total += win_cols[m][k*CHAN_W +: CHAN_W];
                mean[k] = CHAN_W'(total / 9);
            end
            want.red       = mean[0];
            want.green     = mean[1];
            want.blue      = mean[2];
            want.alpha     = win_cols[4][3*CHAN_W +: CHAN_W];
            want.frame_end = (row_pos == h - 1) && (col_pos == w - 1);
            blur_expect = {blur_expect, want};
        end
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = up2;
        win_cols[4] = up1;
        win_cols[5] = pix;
        line_older[idx]  = up1;
        line_recent[idx] = pix;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic check_beat(input logic [PIX_W-1:0] data, input logic last);
        blur_px_t want;
        if (blur_expect.size() == 0) begin
            report_mismatch($sformatf("output beat %08h last %0b with nothing due", data, last));
            return;
        end
        want = blur_expect.pop_front();
        check_field("red", data[0*CHAN_W +: CHAN_W], want.red);
        check_field("green", data[1*CHAN_W +: CHAN_W], want.green);
        check_field("blue", data[2*CHAN_W +: CHAN_W], want.blue);
        check_field("alpha", data[3*CHAN_W +: CHAN_W], want.alpha);
        check_field("tlast", CHAN_W'(last), CHAN_W'(want.frame_end));
    endtask

    // prediction on accepted beats, checking on delivered beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            foreach (win_cols[i]) win_cols[i] = '0;
            foreach (line_recent[i]) begin
                line_recent[i] = '0;
                line_older[i]  = '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                advance_raster(s_tdata);
                accepted_count <= accepted_count + 1;
            end
            if (m_tvalid && m_tready) check_beat(m_tdata, m_tlast);
        end
    end

    // pixel source with random gap bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm && pixel_queue.size() != 0 && $urandom_range(0, 5) == 0) begin
                src_gap  <= $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                s_tdata  <= pixel_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output sink: short random stalls, long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            sink_gap   <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            sink_gap <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] px;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
                0: px[k*CHAN_W +: CHAN_W] = '0;
                1: px[k*CHAN_W +: CHAN_W] = '1;
                default: px[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
            endcase
        end
        return px;
    endfunction

    // register word with random junk above the field now and then
    function automatic logic [CFG_DATA_W-1:0] reg_word(input int unsigned v, input int bits);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : '0;
        junk = junk & ~((CFG_DATA_W'(1) << bits) - 1'b1);
        return junk | CFG_DATA_W'(v);
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] px);
        pixel_queue = {pixel_queue, px};
        pushed_count++;
    endtask

    task automatic queue_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) queue_pixel(random_pixel());
    endtask

    // sender pauses until every pixel is in and every result is out
    task automatic drain_and_settle();
        while (accepted_count != pushed_count || blur_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned      w_val;
        int unsigned      h_val;
        int unsigned      frame_px;
        int unsigned      n;
        int unsigned      first;
        int unsigned      sel;
        int unsigned      random_total;
        logic [PIX_W-1:0] px;
        random_total = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size: start of the first line gives no output
        queue_random(START_ITEMS);
        drain_and_settle();

        // smallest frame: junk above the width field, height below range
        write_reg(REG_FRAME_WIDTH, 16'hF003);
        write_reg(REG_FRAME_HEIGHT, '0);
        for (int k = 0; k < 9; k++) queue_pixel('1);
        for (int k = 0; k < 9; k++) queue_pixel('0);
        // floors: red exact, green just under one, blue just under 255
        for (int k = 0; k < 9; k++) begin
            px[0*CHAN_W +: CHAN_W] = 8'd1;
            px[1*CHAN_W +: CHAN_W] = (k == 8) ? 8'd0 : 8'd1;
            px[2*CHAN_W +: CHAN_W] = (k == 8) ? 8'd254 : 8'd255;
            px[3*CHAN_W +: CHAN_W] = (k == 4) ? 8'hA5 : 8'h5A;
            queue_pixel(px);
        end
        drain_and_settle();

        // unknown index mid-frame must not restart the raster
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        queue_random(7);
        drain_and_settle();
        write_reg(REG_UNUSED_LOW, CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_TOP, '1);
        queue_random(2 * 5 * 4 - 7);
        drain_and_settle();

        // random sizes, mostly whole frames, some abandoned part way
        while (random_total < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 3);
            if (sel != 1) begin
                w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                write_reg(REG_FRAME_WIDTH, reg_word(w_val, WIDTH_REG_W));
            end
            if (sel != 0) begin
                h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                write_reg(REG_FRAME_HEIGHT, reg_word(h_val, HEIGHT_REG_W));
            end
            frame_px = eff_width() * eff_height();
            n = $urandom_range(1, 3) * frame_px;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * frame_px);
            if ($urandom_range(0, 4) == 0) begin
                first = $urandom_range(1, n);
                queue_random(first);
                drain_and_settle();
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)),
                          CFG_DATA_W'($urandom));
                queue_random(n - first);
            end else begin
                queue_random(n);
            end
            drain_and_settle();
            random_total += n;
        end

        // widest line (clamped), start of the first line only
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        queue_random(WIDE_ITEMS);
        drain_and_settle();

        // tallest frame (clamped) at the narrowest line, long output hold
        // mid-frame, no idling from here
        calm = 1'b1;
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, '1);
        first = accepted_count;
        queue_random(3 * TALL_ROWS);
        while (accepted_count < first + HOLD_AFTER) @(posedge aclk);
        stall_req++;
        drain_and_settle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_frame_ctr.sv
design/bb3_window.sv
design/box_blur_3x3_rgba.sv
tb/sv/tb_top.sv
